### rtl/assert_macros.svh
// Assertion macros used by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define MVSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define MVSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mvsm_pkg.sv
// Types, codes and helper functions of the sample mixer.
`default_nettype none
package mvsm_pkg;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  // 0.7 headroom in Q1.15, rounded
  localparam int unsigned HEADROOM_Q15 = 22938;
  localparam logic [16:0] MAX_FRAMES   = 17'd65536;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_START,
    OP_STOP,
    OP_TICK,
    OP_QUERY,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         voice;
    logic               in_range;
    logic               start_ok;
    logic [15:0]        address;
    logic signed [15:0] sample_value;
    logic [16:0]        frames;
    logic               stereo;
    logic [19:0]        step;
    logic [15:0]        gain_l;
    logic [15:0]        gain_r;
    logic               looping;
    logic               playing;
  } entry_t;

  // Effective gain with headroom: (gain * 0.7 + half) >> 15
  function automatic logic [15:0] eff_gain(input logic [15:0] gain);
    logic [30:0] prod;
    prod = 31'(gain) * 31'(HEADROOM_Q15) + 31'd16384;
    return prod[30:15];
  endfunction

endpackage
`default_nettype wire

### rtl/mvsm_if.sv
// Request and result channel interfaces of the sample mixer.
`default_nettype none
interface mvsm_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [3:0]         voice;
  logic [15:0]        address;
  logic signed [15:0] sample_value;
  logic [16:0]        frame_count;
  logic               stereo;
  logic [19:0]        step;
  logic [15:0]        left_level;
  logic [15:0]        right_level;
  logic               looping;
  logic               start_paused;

  modport source(output valid, command, voice, address, sample_value, frame_count,
                 stereo, step, left_level, right_level, looping, start_paused,
                 input ready);
  modport sink(input valid, command, voice, address, sample_value, frame_count,
               stereo, step, left_level, right_level, looping, start_paused,
               output ready);
endinterface

interface mvsm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;
  logic               voice_stopped;
  logic               accepted;

  modport source(output valid, left_out, right_out, voice_stopped, accepted,
                 input ready);
  modport sink(input valid, left_out, right_out, voice_stopped, accepted,
               output ready);
endinterface
`default_nettype wire

### rtl/multi_voice_sample_mixer.sv
// Top level of the multi-voice sample playback mixer.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------------
//  req_in   | in  | valid / ready   | command, voice, address, sample_value, voice
//           |     |                 | setup (frame_count .. start_paused)
//  rsp_out  | out | valid / ready   | left_out, right_out, voice_stopped, accepted
//
// Write, start, stop, query and unknown commands are done as the engine pops them.
// A tick walks the voices in turn: a silent one is only checked, a playing one
// is fetched through the single sample memory read port, interpolated, scaled
// and summed; a wrapped looping voice first subtracts its frame count until in range.
// A two-entry request queue takes up to two requests while the engine works or
// the result register waits; then req_in drops ready until the engine pops.
// Reset (rst, synchronous) stops all voices and empties the queue; sample
// memory holds whatever was written.
`default_nettype none
module multi_voice_sample_mixer import mvsm_pkg::*; #(
  parameter int VOICE_COUNT = 16,
  parameter int WAVE_WORDS  = 65536
) (
  input wire logic   clk,
  input wire logic   rst,
  mvsm_req_if.sink   req_in,
  mvsm_rsp_if.source rsp_out
);
  entry_t dec_entry;
  entry_t q_head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   push;

  // accept whenever the queue has room
  assign req_in.ready = !q_full;
  assign push         = req_in.valid && !q_full;

  mvsm_front #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_front (
    .command     (req_in.command),
    .voice       (req_in.voice),
    .address     (req_in.address),
    .sample_value(req_in.sample_value),
    .frame_count (req_in.frame_count),
    .stereo      (req_in.stereo),
    .step        (req_in.step),
    .left_level  (req_in.left_level),
    .right_level (req_in.right_level),
    .looping     (req_in.looping),
    .start_paused(req_in.start_paused),
    .entry       (dec_entry)
  );

  mvsm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (dec_entry),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_head),
    .empty(q_empty)
  );

  // engine pulls requests in order and owns the result register
  mvsm_back #(
    .VOICE_COUNT(VOICE_COUNT),
    .WAVE_WORDS (WAVE_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(rsp_out.valid),
    .out_ready(rsp_out.ready),
    .left     (rsp_out.left_out),
    .right    (rsp_out.right_out),
    .stopped  (rsp_out.voice_stopped),
    .accepted (rsp_out.accepted)
  );
endmodule
`default_nettype wire

### rtl/mvsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/mvsm_front.sv
// Request decoder: classifies commands and prepares voice settings.
`default_nettype none
module mvsm_front import mvsm_pkg::*; #(
  parameter int VOICE_COUNT = 16
) (
  input  wire logic [2:0]         command,
  input  wire logic [3:0]         voice,
  input  wire logic [15:0]        address,
  input  wire logic signed [15:0] sample_value,
  input  wire logic [16:0]        frame_count,
  input  wire logic               stereo,
  input  wire logic [19:0]        step,
  input  wire logic [15:0]        left_level,
  input  wire logic [15:0]        right_level,
  input  wire logic               looping,
  input  wire logic               start_paused,
  output entry_t                  entry
);
  logic in_range;

  assign in_range = int'(voice) < VOICE_COUNT;

  always_comb begin
    entry = '0;
    unique case (command)
      CMD_WRITE: entry.op = OP_WRITE;
      CMD_START: entry.op = OP_START;
      CMD_STOP:  entry.op = OP_STOP;
      CMD_TICK:  entry.op = OP_TICK;
      CMD_QUERY: entry.op = OP_QUERY;
      default:   entry.op = OP_NONE;
    endcase
    entry.voice        = voice;
    entry.in_range     = in_range;
    entry.start_ok     = in_range && (frame_count != 17'd0);
    entry.address      = address;
    entry.sample_value = sample_value;
    // clamp oversized frame counts
    entry.frames       = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
    entry.stereo       = stereo;
    entry.step         = step;
    entry.gain_l       = eff_gain(left_level);
    entry.gain_r       = eff_gain(right_level);
    entry.looping      = looping;
    entry.playing      = !start_paused;
  end
endmodule
`default_nettype wire

### rtl/mvsm_queue.sv
// Two-entry request queue between decoder and execution engine.
`default_nettype none
module mvsm_queue import mvsm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      din,
  output logic        full,
  input  wire logic   pop,
  output entry_t      dout,
  output logic        empty
);
  entry_t            slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   cnt;

  assign full  = cnt == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = cnt == '0;
  assign dout  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= din;
    end
  end
endmodule
`default_nettype wire

### rtl/mvsm_back.sv
// Execution engine: voice state, sample memory and the mixing walk.
`default_nettype none
`include "assert_macros.svh"
module mvsm_back import mvsm_pkg::*; #(
  parameter int VOICE_COUNT = 16,
  parameter int WAVE_WORDS  = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  entry_t             q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [15:0] left,
  output logic signed [15:0] right,
  output logic               stopped,
  output logic               accepted
);
  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW  = $clog2(WAVE_WORDS);
  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VCHK   = 3'd1;
  localparam logic [2:0] S_WRAP   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_INTERP = 3'd4;
  localparam logic [2:0] S_GAIN   = 3'd5;
  localparam logic [2:0] S_ACC    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic signed [50:0] SAT_HI = 51'sd32767 <<< 31;
  localparam logic signed [50:0] SAT_LO = -(51'sd32768 <<< 31);

  // voice table
  logic [32:0]            vpos  [VOICE_COUNT];
  logic [19:0]            vstep [VOICE_COUNT];
  logic [15:0]            vbase [VOICE_COUNT];
  logic [16:0]            vlen  [VOICE_COUNT];
  logic [15:0]            vgl   [VOICE_COUNT];
  logic [15:0]            vgr   [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] vplay;
  logic [VOICE_COUNT-1:0] vloop;
  logic [VOICE_COUNT-1:0] vster;

  logic [2:0]               state;
  logic [VIW-1:0]           vi;
  logic [16:0]              wa;
  logic [15:0]              fr;
  logic [2:0]               rd_cnt;
  logic signed [15:0]       smp [4];
  logic signed [32:0]       vl;
  logic signed [32:0]       vr;
  logic signed [49:0]       pgl;
  logic signed [49:0]       pgr;
  logic signed [15:0]       sum_l;
  logic signed [15:0]       sum_r;

  logic [VIW-1:0]     vsel;
  logic               can_emit;
  logic               emit;
  logic               cst;
  logic [16:0]        cl;
  logic [2:0]         rd_num;
  logic [17:0]        a1;
  logic [16:0]        wb;
  logic               sel_b;
  logic [16:0]        fm;
  logic [17:0]        woff;
  logic [18:0]        raddr_full;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;
  logic [2:0]         cap_idx;
  logic [1:0]         cap_slot;
  logic signed [15:0] ar;
  logic signed [15:0] br;
  logic signed [16:0] frs;
  logic signed [33:0] vl_n;
  logic signed [33:0] vr_n;
  logic [32:0]        pos_next;

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] s,
                                                 input logic signed [49:0] p);
    logic signed [50:0] t;
    logic signed [19:0] q;
    t = (51'(s) <<< 31) + 51'(p);
    q = t[50:31];
    if (t < 0 && t[30:0] != '0) begin
      q = q + 20'sd1;
    end
    if (t >= SAT_HI) begin
      q = 20'sd32767;
    end else if (t <= SAT_LO) begin
      q = -20'sd32768;
    end
    return q[15:0];
  endfunction

  assign vsel     = VIW'(q_head.voice);
  assign can_emit = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid && can_emit;
  assign emit     = (q_pop && q_head.op != OP_TICK) || (state == S_DONE && can_emit);

  // read address for the current fetch: mono reads a, b; stereo aL aR bL bR
  always_comb begin
    cst        = vster[vi];
    cl         = vlen[vi];
    rd_num     = cst ? 3'd4 : 3'd2;
    a1         = {1'b0, wa} + 18'd1;
    wb         = (a1 < {1'b0, cl}) ? a1[16:0] : wa;
    sel_b      = cst ? rd_cnt[1] : rd_cnt[0];
    fm         = sel_b ? wb : wa;
    woff       = cst ? {fm, rd_cnt[0]} : {1'b0, fm};
    raddr_full = 19'(vbase[vi]) + 19'(woff);
    ram_raddr  = AW'(raddr_full);
    ram_re     = (state == S_READ) && (rd_cnt < rd_num);
    ram_we     = q_pop && (q_head.op == OP_WRITE);
    cap_idx    = rd_cnt - 3'd1;
    cap_slot   = cst ? cap_idx[1:0] : {cap_idx[0], 1'b0};
  end

  // interpolation between neighboring frames, Q16
  always_comb begin
    ar   = cst ? smp[1] : smp[0];
    br   = cst ? smp[3] : smp[2];
    frs  = signed'({1'b0, fr});
    vl_n = (34'(smp[0]) <<< 16) + 34'(17'(smp[2]) - 17'(smp[0])) * 34'(frs);
    vr_n = (34'(ar) <<< 16) + 34'(17'(br) - 17'(ar)) * 34'(frs);
    pos_next = {wa, fr} + 33'(vstep[vi]);
  end

  mvsm_ram #(
    .WIDTH(16),
    .DEPTH(WAVE_WORDS)
  ) u_wave (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(q_head.address)),
    .wdata(q_head.sample_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      vplay     <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            left     <= '0;
            right    <= '0;
            // only a query reports a stopped voice, only a start is refused
            stopped  <= (q_head.op == OP_QUERY) && (!q_head.in_range || !vplay[vsel]);
            accepted <= (q_head.op != OP_START) || q_head.start_ok;
            unique case (q_head.op)
              OP_START: begin
                if (q_head.start_ok) begin
                  vpos[vsel]  <= '0;
                  vbase[vsel] <= q_head.address;
                  vlen[vsel]  <= q_head.frames;
                  vstep[vsel] <= q_head.step;
                  vgl[vsel]   <= q_head.gain_l;
                  vgr[vsel]   <= q_head.gain_r;
                  vster[vsel] <= q_head.stereo;
                  vloop[vsel] <= q_head.looping;
                  vplay[vsel] <= q_head.playing;
                end
              end
              OP_STOP: begin
                if (q_head.in_range) begin
                  vplay[vsel] <= 1'b0;
                  vpos[vsel]  <= '0;
                end
              end
              OP_TICK: begin
                vi    <= '0;
                sum_l <= '0;
                sum_r <= '0;
                state <= S_VCHK;
              end
              default: begin
              end
            endcase
          end
        end
        S_VCHK: begin
          wa <= vpos[vi][32:16];
          fr <= vpos[vi][15:0];
          if (vplay[vi] && cl != 17'd0 && (vpos[vi][32:16] < cl || vloop[vi])) begin
            rd_cnt <= '0;
            state  <= (vpos[vi][32:16] < cl) ? S_READ : S_WRAP;
          end else begin
            // drop a finished one-shot voice
            if (vplay[vi] && cl != 17'd0) begin
              vplay[vi] <= 1'b0;
            end
            if (vi == LAST_VOICE) begin
              state <= S_DONE;
            end else begin
              vi <= vi + 1'b1;
            end
          end
        end
        S_WRAP: begin
          if (wa >= cl) begin
            wa <= wa - cl;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rd_cnt != 3'd0) begin
            smp[cap_slot] <= ram_rdata;
          end
          if (rd_cnt == rd_num) begin
            state <= S_INTERP;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_INTERP: begin
          vl    <= 33'(vl_n);
          vr    <= 33'(vr_n);
          state <= S_GAIN;
        end
        S_GAIN: begin
          pgl   <= 50'(vl) * 50'(signed'({1'b0, vgl[vi]}));
          pgr   <= 50'(vr) * 50'(signed'({1'b0, vgr[vi]}));
          state <= S_ACC;
        end
        S_ACC: begin
          sum_l    <= sat_add(sum_l, pgl);
          sum_r    <= sat_add(sum_r, pgr);
          vpos[vi] <= pos_next;
          if (vi == LAST_VOICE) begin
            state <= S_DONE;
          end else begin
            vi    <= vi + 1'b1;
            state <= S_VCHK;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            left     <= sum_l;
            right    <= sum_r;
            stopped  <= 1'b0;
            accepted <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MVSM_ASSERT_IMPL(a_read_bound, state == S_READ, rd_cnt <= rd_num, "fetch count overran")
  `MVSM_ASSERT_IMPL(a_pop_idle, q_pop, state == S_IDLE && q_valid, "pop outside idle")
  `MVSM_ASSERT_NEXT(a_tick_result, state == S_DONE && can_emit, out_valid, "tick result lost")
endmodule
`default_nettype wire
